// ----- rtl/crsf_pkg.sv -----
// Shared constants, types and the CRC-8 step for the CRSF RC frame parser.
package crsf_pkg;

  localparam int BUFFER_BYTES = 64;
  localparam int CNT_W        = $clog2(BUFFER_BYTES);
  localparam int CMP_W        = 9;

  localparam logic [7:0] SYNC_BYTE   = 8'hC8;
  localparam logic [7:0] TYPE_RC     = 8'h16;
  localparam logic [7:0] MIN_PAYLOAD = 8'd22;
  localparam logic [7:0] LEN_LIMIT   = 8'd253;
  localparam logic [7:0] CRC_POLY    = 8'hD5;

  localparam int N_CH      = 4;
  localparam int CH_W      = 11;
  localparam int CHAN_BITS = N_CH * CH_W;
  localparam int WIDE_BITS = 48;

  localparam int CH_MIN   = 172;
  localparam int CH_MID   = 992;
  localparam int CH_MAX   = 1811;
  localparam int Q_FRAC   = 14;
  localparam int Q_ONE    = 1 << Q_FRAC;
  localparam int D_W      = 12;
  localparam int OUT_W    = 16;
  localparam int THR_W    = 15;

  // centred channels: |d| < 819 fits 10 bits
  localparam int CEN_SPAN   = CH_MAX - CH_MID;
  localparam int CEN_A_W    = 10;
  localparam int CEN_NUM_W  = CEN_A_W + Q_FRAC;
  localparam int CEN_SHIFT  = CEN_NUM_W + 10;
  localparam int CEN_MAG_W  = 25;
  localparam int CEN_PROD_W = CEN_NUM_W + CEN_MAG_W;
  localparam logic [CEN_MAG_W-1:0] CEN_MAGIC =
    CEN_MAG_W'(((64'd1 << CEN_SHIFT) + 64'(CEN_SPAN) - 64'd1) / 64'(CEN_SPAN));

  // throttle: d < 1639 fits 11 bits
  localparam int THR_SPAN   = CH_MAX - CH_MIN;
  localparam int THR_A_W    = 11;
  localparam int THR_NUM_W  = THR_A_W + Q_FRAC;
  localparam int THR_SHIFT  = THR_NUM_W + 11;
  localparam int THR_MAG_W  = 26;
  localparam int THR_PROD_W = THR_NUM_W + THR_MAG_W;
  localparam logic [THR_MAG_W-1:0] THR_MAGIC =
    THR_MAG_W'(((64'd1 << THR_SHIFT) + 64'(THR_SPAN) - 64'd1) / 64'(THR_SPAN));

  typedef struct packed {
    logic                      vld;
    logic [N_CH-1:0][CH_W-1:0] ch;
  } crsf_raw_t;

  typedef struct packed {
    logic              neg;
    logic              hi;
    logic              lo;
    logic [Q_FRAC-1:0] q;
  } crsf_cen_t;

  typedef struct packed {
    logic              zero;
    logic              hi;
    logic [Q_FRAC-1:0] q;
  } crsf_thr_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ----- rtl/crsf_in_if.sv -----
// Byte request channel into the parser.
interface crsf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/crsf_out_if.sv -----
// Normalised stick request channel out of the parser.
interface crsf_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll;
  logic signed [15:0] pitch;
  logic        [14:0] throttle;
  logic signed [15:0] yaw;

  modport source (output valid, output roll, output pitch, output throttle, output yaw,
                  input ready);
  modport sink   (input valid, input roll, input pitch, input throttle, input yaw,
                  output ready);
endinterface

// ----- rtl/crsf_frame.sv -----
// Byte-level frame tracker: sync hunt, length check, running CRC, channel capture.
module crsf_frame (
  input  logic                clk,
  input  logic                rst_n,
  crsf_in_if.sink             in_ch,
  input  logic                advance,
  output crsf_pkg::crsf_raw_t raw
);
  import crsf_pkg::*;

  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [7:0]           len_r, len_nxt;
  logic [7:0]           crc_r, crc_nxt;
  logic                 type_r, type_nxt;
  logic [CHAN_BITS-1:0] bits_r, bits_nxt;
  logic                 v1_r;
  logic [N_CH-1:0][CH_W-1:0] ch_r;
  logic [WIDE_BITS-1:0] wide;
  logic                 ready, take, good;
  logic [7:0]           b;

  assign b           = in_ch.rx_byte;
  assign ready       = !v1_r || advance;
  assign in_ch.ready = ready;
  assign take        = in_ch.valid && ready;

  always_comb begin
    cnt_nxt  = cnt_r;
    len_nxt  = len_r;
    crc_nxt  = crc_r;
    type_nxt = type_r;
    bits_nxt = bits_r;
    good     = 1'b0;
    wide     = {{(WIDE_BITS-CHAN_BITS){1'b0}}, bits_r};
    if (take) begin
      if (cnt_r == '0) begin
        if (b == SYNC_BYTE) begin
          crc_nxt  = '0;
          type_nxt = 1'b0;
          bits_nxt = '0;
          cnt_nxt  = CNT_W'(1);
        end
      end else if (cnt_r == CNT_W'(1)) begin
        len_nxt = b;
        if (b >= LEN_LIMIT || (CMP_W'(b) + CMP_W'(3)) > CMP_W'(BUFFER_BYTES)) begin
          cnt_nxt = '0;
        end else begin
          cnt_nxt = CNT_W'(2);
        end
      end else if (CMP_W'(cnt_r) >= CMP_W'(len_r) + CMP_W'(2)) begin
        cnt_nxt = '0;
        good    = type_r && (len_r >= MIN_PAYLOAD) && (crc_r == b);
      end else begin
        crc_nxt = crc8_update(crc_r, b);
        if (cnt_r == CNT_W'(2)) begin
          type_nxt = (b == TYPE_RC);
        end
        for (int k = 0; k < WIDE_BITS / 8; k++) begin
          if (cnt_r == CNT_W'(k + 3)) begin
            wide[8*k +: 8] = wide[8*k +: 8] | b;
          end
        end
        bits_nxt = wide[CHAN_BITS-1:0];
        cnt_nxt  = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      len_r  <= '0;
      crc_r  <= '0;
      type_r <= 1'b0;
      bits_r <= '0;
      v1_r   <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      len_r  <= len_nxt;
      crc_r  <= crc_nxt;
      type_r <= type_nxt;
      bits_r <= bits_nxt;
      if (ready) begin
        v1_r <= take && good;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && good) begin
      for (int k = 0; k < N_CH; k++) begin
        ch_r[k] <= bits_r[CH_W*k +: CH_W];
      end
    end
  end

  assign raw.vld = v1_r;
  assign raw.ch  = ch_r;

endmodule

// ----- rtl/crsf_conv.sv -----
// Two-stage channel scaling: reciprocal multiply, then sign and clamp into the output register.
module crsf_conv (
  input  logic                clk,
  input  logic                rst_n,
  input  crsf_pkg::crsf_raw_t raw,
  output logic                raw_take,
  crsf_out_if.source          out_ch
);
  import crsf_pkg::*;

  logic      v2_r, v3_r, rdy2, rdy3;
  crsf_cen_t roll_s_r, pitch_s_r, yaw_s_r;
  crsf_thr_t thr_s_r;
  logic signed [OUT_W-1:0] roll_r, pitch_r, yaw_r;
  logic        [THR_W-1:0] thr_r;

  function automatic crsf_cen_t cen_stage(input logic [CH_W-1:0] v);
    logic signed [D_W-1:0]  d;
    logic [D_W-1:0]         a;
    logic [CEN_NUM_W-1:0]   n;
    logic [CEN_PROD_W-1:0]  p;
    crsf_cen_t              s;
    d     = $signed({1'b0, v}) - $signed(D_W'(CH_MID));
    s.neg = d < $signed(D_W'(0));
    s.hi  = d >= $signed(D_W'(CEN_SPAN));
    s.lo  = d <= -$signed(D_W'(CEN_SPAN));
    a     = s.neg ? D_W'(-d) : D_W'(d);
    n     = {a[CEN_A_W-1:0], {Q_FRAC{1'b0}}} + CEN_NUM_W'(CEN_SPAN / 2);
    p     = CEN_PROD_W'(n) * CEN_PROD_W'(CEN_MAGIC);
    s.q   = p[CEN_SHIFT +: Q_FRAC];
    return s;
  endfunction

  function automatic crsf_thr_t thr_stage(input logic [CH_W-1:0] v);
    logic signed [D_W-1:0]  d;
    logic [THR_NUM_W-1:0]   n;
    logic [THR_PROD_W-1:0]  p;
    crsf_thr_t              s;
    d      = $signed({1'b0, v}) - $signed(D_W'(CH_MIN));
    s.zero = d <= $signed(D_W'(0));
    s.hi   = d >= $signed(D_W'(THR_SPAN));
    n      = {d[THR_A_W-1:0], {Q_FRAC{1'b0}}} + THR_NUM_W'(THR_SPAN / 2);
    p      = THR_PROD_W'(n) * THR_PROD_W'(THR_MAGIC);
    s.q    = p[THR_SHIFT +: Q_FRAC];
    return s;
  endfunction

  function automatic logic signed [OUT_W-1:0] cen_final(input crsf_cen_t s);
    logic signed [OUT_W-1:0] m;
    m = $signed({{(OUT_W-Q_FRAC){1'b0}}, s.q});
    if (s.hi) begin
      return $signed(OUT_W'(Q_ONE));
    end else if (s.lo) begin
      return -$signed(OUT_W'(Q_ONE));
    end
    return s.neg ? -m : m;
  endfunction

  function automatic logic [THR_W-1:0] thr_final(input crsf_thr_t s);
    if (s.zero) begin
      return '0;
    end else if (s.hi) begin
      return THR_W'(Q_ONE);
    end
    return {{(THR_W-Q_FRAC){1'b0}}, s.q};
  endfunction

  assign rdy3     = !v3_r || out_ch.ready;
  assign rdy2     = !v2_r || rdy3;
  assign raw_take = rdy2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy2) begin
        v2_r <= raw.vld;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && raw.vld) begin
      roll_s_r  <= cen_stage(raw.ch[0]);
      pitch_s_r <= cen_stage(raw.ch[1]);
      thr_s_r   <= thr_stage(raw.ch[2]);
      yaw_s_r   <= cen_stage(raw.ch[3]);
    end
    if (rdy3 && v2_r) begin
      roll_r  <= cen_final(roll_s_r);
      pitch_r <= cen_final(pitch_s_r);
      thr_r   <= thr_final(thr_s_r);
      yaw_r   <= cen_final(yaw_s_r);
    end
  end

  assign out_ch.valid    = v3_r;
  assign out_ch.roll     = roll_r;
  assign out_ch.pitch    = pitch_r;
  assign out_ch.throttle = thr_r;
  assign out_ch.yaw      = yaw_r;

endmodule

// ----- rtl/crsf_rc_frame_parser.sv -----
// Top level of the CRSF RC channels frame parser.
//
// in_ch takes one received link byte per request (valid/ready). The parser
// hunts for the 0xC8 sync byte, checks the length against the frame buffer
// size, runs CRC-8 (poly 0xD5) over type and payload, and captures the first
// four 11-bit channels. A complete RC channels frame with good CRC gives one
// request on out_ch: roll, pitch, yaw in Q1.14 (+-16384) and throttle 0..16384.
// Every other byte gives no request.
// Throughput: one byte per cycle while in_ch.ready is high, set by the CRC
// step and byte capture. After the CRC byte is taken, the result passes
// through the capture register, multiply stage and clamp/output register.
// When out_ch stalls, the three result slots fill in turn; in_ch.ready drops
// only once all of them hold a result, and nothing is lost.
// Reset (rst_n low, synchronous) empties the pipeline and returns the parser
// to sync hunting with CRC, length and channel capture cleared.
module crsf_rc_frame_parser (
  input  logic       clk,
  input  logic       rst_n,
  crsf_in_if.sink    in_ch,
  crsf_out_if.source out_ch
);
  import crsf_pkg::*;

  crsf_raw_t raw;
  logic      raw_take;

  crsf_frame u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .advance (raw_take),
    .raw     (raw)
  );

  crsf_conv u_conv (
    .clk      (clk),
    .rst_n    (rst_n),
    .raw      (raw),
    .raw_take (raw_take),
    .out_ch   (out_ch)
  );

endmodule

// ----- rtl/crsf_chk.sv -----
// Port-level checks for the CRSF RC frame parser, bound to the top level.
module crsf_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] roll,
  input logic signed [15:0] pitch,
  input logic        [14:0] throttle,
  input logic signed [15:0] yaw
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({roll, pitch, throttle, yaw}))
    else $error("stalled result changed or dropped");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> throttle <= 15'd16384
                  && roll >= -16'sd16384 && roll <= 16'sd16384
                  && pitch >= -16'sd16384 && pitch <= 16'sd16384
                  && yaw >= -16'sd16384 && yaw <= 16'sd16384)
    else $error("result outside Q1.14 range");

  a_back_press: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("byte input blocked without a stalled result");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 3))
    else $error("result without a byte taken three cycles earlier");

endmodule

bind crsf_rc_frame_parser crsf_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .roll      (out_ch.roll),
  .pitch     (out_ch.pitch),
  .throttle  (out_ch.throttle),
  .yaw       (out_ch.yaw)
);

// ----- verif/crsf_stick_checker.sv -----
// Checker for the CRSF RC frame parser: predicts each stick request and compares it.
`timescale 1ns / 100ps

module crsf_stick_checker (
  input  logic clk,
  input  logic rst_n,
  crsf_in_if   in_ch,
  crsf_out_if  out_ch,
  output int   fail_count,
  output int   outstanding
);
  import crsf_pkg::*;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic        [14:0] throttle;
    logic signed [15:0] yaw;
  } stick_t;

  stick_t sticks_due [$];

  int          pos;
  logic [7:0]  len_byte;
  logic [7:0]  crc_acc;
  bit          is_rc;
  logic [47:0] capture;

  function automatic logic [7:0] crc8_d5(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    r = acc ^ b;
    repeat (8) r = {r[6:0], 1'b0} ^ (r[7] ? CRC_POLY : 8'h00);
    return r;
  endfunction

  function automatic logic signed [15:0] centre_q14(input logic [10:0] v);
    int d;
    int span;
    int q;
    d    = int'(v) - CH_MID;
    span = CH_MAX - CH_MID;
    if (d >= span) q = Q_ONE;
    else if (d <= -span) q = -Q_ONE;
    else if (d >= 0) q = (d * Q_ONE + span / 2) / span;
    else q = -((-d * Q_ONE + span / 2) / span);
    return 16'(q);
  endfunction

  function automatic logic [14:0] throttle_q14(input logic [10:0] v);
    int d;
    int span;
    int q;
    d    = int'(v) - CH_MIN;
    span = CH_MAX - CH_MIN;
    if (d <= 0) q = 0;
    else if (d >= span) q = Q_ONE;
    else q = (d * Q_ONE + span / 2) / span;
    return 15'(q);
  endfunction

  task automatic parse_byte(input logic [7:0] b);
    stick_t s;
    if (pos == 0) begin
      if (b == SYNC_BYTE) begin
        crc_acc = 8'h00;
        is_rc   = 1'b0;
        capture = '0;
        pos     = 1;
      end
    end else if (pos == 1) begin
      len_byte = b;
      pos = (b >= LEN_LIMIT || int'(b) + 3 > BUFFER_BYTES) ? 0 : 2;
    end else if (pos >= int'(len_byte) + 2) begin
      pos = 0;
      if (is_rc && len_byte >= MIN_PAYLOAD && crc_acc == b) begin
        s.roll     = centre_q14(capture[10:0]);
        s.pitch    = centre_q14(capture[21:11]);
        s.throttle = throttle_q14(capture[32:22]);
        s.yaw      = centre_q14(capture[43:33]);
        sticks_due.push_back(s);
      end
    end else begin
      crc_acc = crc8_d5(crc_acc, b);
      if (pos == 2) is_rc = (b == TYPE_RC);
      if (pos >= 3 && pos <= 8) capture[8*(pos-3) +: 8] = b;
      pos = pos + 1;
    end
  endtask

  task automatic check_field(input string name, input logic signed [16:0] want,
                             input logic signed [16:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_stick();
    stick_t s;
    if (sticks_due.size() == 0) begin
      $display("%0t: stick request expected none, got roll %0d pitch %0d throttle %0d yaw %0d",
               $time, out_ch.roll, out_ch.pitch, out_ch.throttle, out_ch.yaw);
      fail_count++;
    end else begin
      s = sticks_due.pop_front();
      check_field("roll", s.roll, out_ch.roll);
      check_field("pitch", s.pitch, out_ch.pitch);
      check_field("throttle", s.throttle, out_ch.throttle);
      check_field("yaw", s.yaw, out_ch.yaw);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pos        = 0;
      len_byte   = 8'h00;
      crc_acc    = 8'h00;
      is_rc      = 1'b0;
      capture    = '0;
      fail_count = 0;
      sticks_due.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) check_stick();
      if (in_ch.valid && in_ch.ready) parse_byte(in_ch.rx_byte);
    end
    outstanding = sticks_due.size();
  end

endmodule

// ----- verif/tb.sv -----
// Testbench top for the CRSF RC frame parser: byte stimulus, output stalls and verdict.
`timescale 1ns / 100ps

module tb;
  import crsf_pkg::*;

  localparam int QUIET_LIMIT  = 1000;
  localparam int RANDOM_BYTES = 2000;
  localparam int PHASES       = 10;

  logic clk;
  logic rst_n;

  crsf_in_if  in_if ();
  crsf_out_if out_if ();

  int fails;
  int due;
  int bytes_sent = 0;
  int rand_start;
  int quiet;
  bit gaps_on    = 1'b0;
  bit stalls_on  = 1'b0;

  crsf_rc_frame_parser DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  crsf_stick_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_if),
    .out_ch     (out_if),
    .fail_count (fails),
    .outstanding(due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sink side back-pressure
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stalls_on && $urandom_range(0, 9) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      out_if.ready <= 1'b1;
    end
  end

  initial begin : watchdog
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("tb: done, errors");
    $finish;
  end

  task automatic push_byte(input logic [7:0] b);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.rx_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] len, input logic [7:0] kind,
                            input logic [10:0] c0, input logic [10:0] c1,
                            input logic [10:0] c2, input logic [10:0] c3,
                            input bit spoil_crc);
    logic [47:0] chans;
    logic [7:0]  crc;
    logic [7:0]  b;
    int          body;
    chans = {4'($urandom), c3, c2, c1, c0};
    crc   = 8'h00;
    push_byte(SYNC_BYTE);
    push_byte(len);
    if (len >= LEN_LIMIT || int'(len) + 3 > BUFFER_BYTES) return;
    body = int'(len);
    for (int k = 0; k < body; k++) begin
      if (k == 0) b = kind;
      else if (k <= 6) b = chans[8*(k-1) +: 8];
      else b = 8'($urandom);
      crc = crc8_update(crc, b);
      push_byte(b);
    end
    push_byte(spoil_crc ? crc ^ 8'($urandom_range(1, 255)) : crc);
  endtask

  function automatic logic [10:0] pick_channel();
    logic [10:0] marks [11];
    marks = '{11'd0, 11'd171, 11'd172, 11'd173, 11'd991, 11'd992, 11'd993,
              11'd1810, 11'd1811, 11'd1812, 11'd2047};
    case ($urandom_range(0, 5))
      0: return marks[$urandom_range(0, 10)];
      1: return 11'($urandom_range(0, 2047));
      default: return 11'($urandom_range(CH_MIN, CH_MAX));
    endcase
  endfunction

  task automatic send_random_frame();
    int          pick;
    logic [7:0]  len;
    logic [7:0]  kind;
    pick = $urandom_range(0, 99);
    len  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(MIN_PAYLOAD, BUFFER_BYTES - 3))
                                       : 8'($urandom_range(MIN_PAYLOAD, MIN_PAYLOAD + 4));
    kind = TYPE_RC;
    if (pick < 65) begin
      send_frame(len, kind, pick_channel(), pick_channel(), pick_channel(), pick_channel(), 1'b0);
    end else if (pick < 75) begin
      send_frame(len, kind, pick_channel(), pick_channel(), pick_channel(), pick_channel(), 1'b1);
    end else if (pick < 80) begin
      kind = 8'($urandom);
      if (kind == TYPE_RC) kind = kind ^ 8'h01;
      send_frame(len, kind, pick_channel(), pick_channel(), pick_channel(), pick_channel(), 1'b0);
    end else if (pick < 85) begin
      len = 8'($urandom_range(0, MIN_PAYLOAD - 1));
      send_frame(len, kind, pick_channel(), pick_channel(), pick_channel(), pick_channel(), 1'b0);
    end else if (pick < 90) begin
      len = 8'($urandom_range(BUFFER_BYTES - 2, 255));
      send_frame(len, kind, 11'd0, 11'd0, 11'd0, 11'd0, 1'b0);
    end else begin
      repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.rx_byte = 8'h00;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // noise while hunting
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(TYPE_RC);
    send_frame(MIN_PAYLOAD, TYPE_RC, 11'd992, 11'd992, 11'd172, 11'd992, 1'b0);
    send_frame(MIN_PAYLOAD, TYPE_RC, 11'd0, 11'd0, 11'd0, 11'd0, 1'b0);
    send_frame(8'd24, TYPE_RC, 11'd2047, 11'd2047, 11'd2047, 11'd2047, 1'b0);
    send_frame(MIN_PAYLOAD, TYPE_RC, 11'd172, 11'd1811, 11'd1811, 11'd173, 1'b0);
    send_frame(MIN_PAYLOAD, TYPE_RC, 11'd993, 11'd991, 11'd173, 11'd1810, 1'b0);
    send_frame(8'(BUFFER_BYTES - 3), TYPE_RC, 11'd1000, 11'd500, 11'd1500, 11'd2000, 1'b0);
    // oversize lengths, including the wrapped ones
    send_frame(8'(BUFFER_BYTES - 2), TYPE_RC, 11'd0, 11'd0, 11'd0, 11'd0, 1'b0);
    send_frame(LEN_LIMIT, TYPE_RC, 11'd0, 11'd0, 11'd0, 11'd0, 1'b0);
    send_frame(8'd255, TYPE_RC, 11'd0, 11'd0, 11'd0, 11'd0, 1'b0);
    // sync as length byte aborts and is not taken as a new sync
    push_byte(SYNC_BYTE);
    push_byte(SYNC_BYTE);
    send_frame(MIN_PAYLOAD, TYPE_RC, 11'd1200, 11'd800, 11'd900, 11'd1100, 1'b0);
    send_frame(MIN_PAYLOAD, TYPE_RC ^ 8'h01, 11'd992, 11'd992, 11'd992, 11'd992, 1'b0);
    send_frame(MIN_PAYLOAD - 1, TYPE_RC, 11'd992, 11'd992, 11'd992, 11'd992, 1'b0);
    send_frame(MIN_PAYLOAD, TYPE_RC, 11'd992, 11'd992, 11'd992, 11'd992, 1'b1);
    send_frame(8'd0, TYPE_RC, 11'd0, 11'd0, 11'd0, 11'd0, 1'b0);
    send_frame(8'd1, TYPE_RC, 11'd0, 11'd0, 11'd0, 11'd0, 1'b0);
    send_frame(8'd2, TYPE_RC, 11'd0, 11'd0, 11'd0, 11'd0, 1'b0);

    rand_start = bytes_sent;
    for (int phase = 0; phase < PHASES; phase++) begin
      gaps_on   = (phase < PHASES - 2) && ($urandom_range(0, 3) != 0);
      stalls_on = (phase < PHASES - 2) && ($urandom_range(0, 3) != 0);
      while (bytes_sent < rand_start + (RANDOM_BYTES / PHASES) * (phase + 1))
        send_random_frame();
    end
    in_if.valid <= 1'b0;

    while (due != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (fails == 0 && due == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/crsf_pkg.sv
rtl/crsf_in_if.sv
rtl/crsf_out_if.sv
rtl/crsf_frame.sv
rtl/crsf_conv.sv
rtl/crsf_rc_frame_parser.sv
rtl/crsf_chk.sv
verif/crsf_stick_checker.sv
verif/tb.sv
